/* rtl/core/merge_network_8x8_core_defines.svh */
// ----------------------------------------------------------------------------
// merge_network_8x8_core_defines
// Assertion macros for the merge network core. Both expect clk_i and rst_ni
// in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef MERGE_NETWORK_8X8_CORE_DEFINES_SVH
`define MERGE_NETWORK_8X8_CORE_DEFINES_SVH

// same-cycle implication
`define MNET_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("merge network check failed");

// next-cycle implication
`define MNET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("merge network check failed");

`endif

/* rtl/core/mnet_pkg.sv */
// ----------------------------------------------------------------------------
// mnet_pkg
// Shared constants of the 8+8 merge network.
// ----------------------------------------------------------------------------
package mnet_pkg;

  localparam int unsigned ELEMENT_WIDTH = 32;  // default element width
  localparam int unsigned SLOT_W        = 32;  // element slot in a port pair
  localparam int unsigned PAIR_W        = 2 * SLOT_W;
  localparam int unsigned LANES         = 4;   // lanes of one 4+4 merge
  localparam int unsigned NUM_VEC       = 4;   // 4-lane vectors in flight
  localparam int unsigned NUM_STAGES    = 4;

endpackage

/* rtl/core/mnet_pass2.sv */
// ----------------------------------------------------------------------------
// mnet_pass2
// Two compare-exchange passes of a 4+4 merge: lanewise min/max, then the
// min vector rotated down one lane. Four passes make a full 4+4 merge.
// ----------------------------------------------------------------------------
module mnet_pass2 #(
  parameter int unsigned ELEM_W = mnet_pkg::ELEMENT_WIDTH
) (
  input  logic [mnet_pkg::LANES-1:0][ELEM_W-1:0] t_i,
  input  logic [mnet_pkg::LANES-1:0][ELEM_W-1:0] mx_i,
  output logic [mnet_pkg::LANES-1:0][ELEM_W-1:0] t_o,
  output logic [mnet_pkg::LANES-1:0][ELEM_W-1:0] mx_o
);
  import mnet_pkg::*;

  always_comb begin
    logic [LANES-1:0][ELEM_W-1:0] mn0, mx0, t1, mn1;
    for (int i = 0; i < LANES; i++) begin
      mn0[i] = (t_i[i] < mx_i[i]) ? t_i[i] : mx_i[i];
      mx0[i] = (t_i[i] < mx_i[i]) ? mx_i[i] : t_i[i];
    end
    for (int i = 0; i < LANES; i++) begin
      t1[i] = mn0[(i + 1) % LANES];
    end
    for (int i = 0; i < LANES; i++) begin
      mn1[i]  = (t1[i] < mx0[i]) ? t1[i] : mx0[i];
      mx_o[i] = (t1[i] < mx0[i]) ? mx0[i] : t1[i];
    end
    for (int i = 0; i < LANES; i++) begin
      t_o[i] = mn1[(i + 1) % LANES];
    end
  end

endmodule

/* rtl/core/mnet_pipe_reg.sv */
// ----------------------------------------------------------------------------
// mnet_pipe_reg
// One pipeline register with valid/ready. Takes a new transfer whenever it
// is empty or its content leaves in the same cycle.
// ----------------------------------------------------------------------------
module mnet_pipe_reg #(
  parameter int unsigned DATA_W = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [DATA_W-1:0] data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [DATA_W-1:0] data_o
);

  logic              valid_q;
  logic [DATA_W-1:0] data_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/core/merge_network_8x8_core.sv */
// ----------------------------------------------------------------------------
// merge_network_8x8_core
// Merges two ascending lists of eight unsigned elements into one ascending
// list of sixteen.
// ----------------------------------------------------------------------------
// Four register stages, two compare-exchange levels each: stages 1-2 run the
// 4+4 merges of the low and high halves side by side, stages 3-4 merge the
// upper result of the first against the lower result of the second. Results
// leave the last stage register, and one item per cycle streams through
// when the output side keeps up; the four stage registers bound the items in
// flight. Elements use the low ELEM_W bits of each 32-bit slot; upper slot
// bits are ignored on input and zero on output.
// ----------------------------------------------------------------------------
`include "merge_network_8x8_core_defines.svh"

module merge_network_8x8_core #(
  parameter int unsigned ELEM_W = mnet_pkg::ELEMENT_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mnet_pkg::PAIR_W-1:0] a_pair0_i,
  input  logic [mnet_pkg::PAIR_W-1:0] a_pair1_i,
  input  logic [mnet_pkg::PAIR_W-1:0] a_pair2_i,
  input  logic [mnet_pkg::PAIR_W-1:0] a_pair3_i,
  input  logic [mnet_pkg::PAIR_W-1:0] b_pair0_i,
  input  logic [mnet_pkg::PAIR_W-1:0] b_pair1_i,
  input  logic [mnet_pkg::PAIR_W-1:0] b_pair2_i,
  input  logic [mnet_pkg::PAIR_W-1:0] b_pair3_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mnet_pkg::PAIR_W-1:0] out_pair0_o,
  output logic [mnet_pkg::PAIR_W-1:0] out_pair1_o,
  output logic [mnet_pkg::PAIR_W-1:0] out_pair2_o,
  output logic [mnet_pkg::PAIR_W-1:0] out_pair3_o,
  output logic [mnet_pkg::PAIR_W-1:0] out_pair4_o,
  output logic [mnet_pkg::PAIR_W-1:0] out_pair5_o,
  output logic [mnet_pkg::PAIR_W-1:0] out_pair6_o,
  output logic [mnet_pkg::PAIR_W-1:0] out_pair7_o
);
  import mnet_pkg::*;

  typedef logic [LANES-1:0][ELEM_W-1:0] vec_t;
  typedef vec_t [NUM_VEC-1:0]           stage_t;

  localparam int unsigned STAGE_W = $bits(stage_t);

  stage_t                s_d   [NUM_STAGES];
  stage_t                s_q   [NUM_STAGES];
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES:0]   vld_in;
  logic [PAIR_W-1:0]     a_pair [LANES];
  logic [PAIR_W-1:0]     b_pair [LANES];
  logic [PAIR_W-1:0]     o_pair [2*LANES];
  stage_t                in_vec;
  logic [ELEM_W*4*LANES-1:0] res;

  assign a_pair[0] = a_pair0_i;
  assign a_pair[1] = a_pair1_i;
  assign a_pair[2] = a_pair2_i;
  assign a_pair[3] = a_pair3_i;
  assign b_pair[0] = b_pair0_i;
  assign b_pair[1] = b_pair1_i;
  assign b_pair[2] = b_pair2_i;
  assign b_pair[3] = b_pair3_i;

  // vector 0/1: A/B low halves, vector 2/3: A/B high halves
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      in_vec[2*((2*k)/LANES)][(2*k)%LANES]       = a_pair[k][ELEM_W-1:0];
      in_vec[2*((2*k)/LANES)][(2*k)%LANES+1]     = a_pair[k][SLOT_W +: ELEM_W];
      in_vec[2*((2*k)/LANES)+1][(2*k)%LANES]     = b_pair[k][ELEM_W-1:0];
      in_vec[2*((2*k)/LANES)+1][(2*k)%LANES+1]   = b_pair[k][SLOT_W +: ELEM_W];
    end
  end

  // stages 1-2: both half merges
  mnet_pass2 #(.ELEM_W(ELEM_W)) u_p0_lo (
    .t_i(in_vec[0]), .mx_i(in_vec[1]), .t_o(s_d[0][0]), .mx_o(s_d[0][1])
  );
  mnet_pass2 #(.ELEM_W(ELEM_W)) u_p0_hi (
    .t_i(in_vec[2]), .mx_i(in_vec[3]), .t_o(s_d[0][2]), .mx_o(s_d[0][3])
  );
  mnet_pass2 #(.ELEM_W(ELEM_W)) u_p1_lo (
    .t_i(s_q[0][0]), .mx_i(s_q[0][1]), .t_o(s_d[1][0]), .mx_o(s_d[1][1])
  );
  mnet_pass2 #(.ELEM_W(ELEM_W)) u_p1_hi (
    .t_i(s_q[0][2]), .mx_i(s_q[0][3]), .t_o(s_d[1][2]), .mx_o(s_d[1][3])
  );

  // stages 3-4: middle merge, outer vectors ride along
  assign s_d[2][0] = s_q[1][0];
  assign s_d[2][3] = s_q[1][3];
  mnet_pass2 #(.ELEM_W(ELEM_W)) u_p2_mid (
    .t_i(s_q[1][1]), .mx_i(s_q[1][2]), .t_o(s_d[2][1]), .mx_o(s_d[2][2])
  );
  assign s_d[3][0] = s_q[2][0];
  assign s_d[3][3] = s_q[2][3];
  mnet_pass2 #(.ELEM_W(ELEM_W)) u_p3_mid (
    .t_i(s_q[2][1]), .mx_i(s_q[2][2]), .t_o(s_d[3][1]), .mx_o(s_d[3][2])
  );

  assign vld_in[0]          = in_valid_i;
  assign rdy[NUM_STAGES]    = out_ready_i;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    mnet_pipe_reg #(.DATA_W(STAGE_W)) u_reg (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_in[g]),
      .ready_o (rdy[g]),
      .data_i  (s_d[g]),
      .valid_o (vld_in[g+1]),
      .ready_i (rdy[g+1]),
      .data_o  (s_q[g])
    );
    assign vld_q[g] = vld_in[g+1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  assign res = s_q[NUM_STAGES-1];

  always_comb begin
    for (int k = 0; k < 2*LANES; k++) begin
      o_pair[k][SLOT_W-1:0]      = SLOT_W'(res[(2*k)*ELEM_W +: ELEM_W]);
      o_pair[k][PAIR_W-1:SLOT_W] = SLOT_W'(res[(2*k+1)*ELEM_W +: ELEM_W]);
    end
  end

  assign out_pair0_o = o_pair[0];
  assign out_pair1_o = o_pair[1];
  assign out_pair2_o = o_pair[2];
  assign out_pair3_o = o_pair[3];
  assign out_pair4_o = o_pair[4];
  assign out_pair5_o = o_pair[5];
  assign out_pair6_o = o_pair[6];
  assign out_pair7_o = o_pair[7];

  // ---- checks ----
  logic in_xfer, out_xfer;
  int   n_vld, n_delta;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign n_vld    = $countones(vld_q);
  assign n_delta  = int'(in_xfer) - int'(out_xfer);

  // input backpressure only when every stage holds an item
  `MNET_ASSERT_NOW(a_full_on_stall, !in_ready_o, &vld_q)
  // items in flight change only by transfers
  `MNET_ASSERT_NEXT(a_count_kept, 1'b1, n_vld == $past(n_vld) + $past(n_delta))
  // a full pipe with a taken result moves every stage
  `MNET_ASSERT_NOW(a_flow_on_take, out_ready_i, in_ready_o)

endmodule
